@@ src/escaped_frame_deframer_crc8_core_defines.svh @@
// Assertion macros for the deframer core
`ifndef ESCAPED_FRAME_DEFRAMER_CRC8_CORE_DEFINES_SVH
`define ESCAPED_FRAME_DEFRAMER_CRC8_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define EFD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define EFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define EFD_ASSERT_IMPL(label, ante, cons)
`define EFD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ src/efd_crc8_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package efd_crc8_pkg;

    localparam int PAYLOAD_SIZE = 64;
    localparam int CNT_W        = $clog2(PAYLOAD_SIZE);
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_START_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_CODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CODE = 2'd2;

    localparam logic [7:0] START_CODE_RST  = 8'd192;
    localparam logic [7:0] END_CODE_RST    = 8'd193;
    localparam logic [7:0] ESCAPE_CODE_RST = 8'd219;
    localparam logic [7:0] ESC_XOR         = 8'hFF;

    localparam logic [7:0] CRC_BIT_TERMS [8] = '{
        8'h5e, 8'hbc, 8'h61, 8'hc2, 8'h9d, 8'h23, 8'h46, 8'h8c
    };

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_CMD     = 2'd1,
        MODE_PAYLOAD = 2'd2,
        MODE_ESC     = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_CMD     = 3'd0,
        KIND_PAYLOAD = 3'd1,
        KIND_GOOD    = 3'd2,
        KIND_BAD     = 3'd3,
        KIND_ABANDON = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] end_code;
        logic [7:0] escape_code;
    } cfg_t;

    // Dallas/Maxim CRC-8, reflected, one byte
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] r;
        x = crc ^ b;
        r = 8'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (x[i])
            begin
                r = r ^ CRC_BIT_TERMS[i];
            end
        end
        return r;
    endfunction

    // payload bytes passed on, saturated at 63
    function automatic logic [5:0] delivered_len(input logic [CNT_W-1:0] cnt);
        int n;
        n = (cnt == '0) ? 0 : int'(cnt) - 1;
        if (n > 63)
        begin
            n = 63;
        end
        return 6'(n);
    endfunction

endpackage

`default_nettype wire

@@ src/efd_crc8_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface efd_crc8_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface efd_crc8_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data;
    logic [5:0] frame_length;

    modport source (output valid, output kind, output data, output frame_length, input ready);
    modport sink (input valid, input kind, input data, input frame_length, output ready);
endinterface

`default_nettype wire

@@ src/efd_crc8_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module efd_crc8_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [efd_crc8_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                         cfg_data,
    output efd_crc8_pkg::cfg_t                      cfg
);
    import efd_crc8_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_START_CODE:  cfg_next.start_code  = cfg_data;
                REG_END_CODE:    cfg_next.end_code    = cfg_data;
                REG_ESCAPE_CODE: cfg_next.escape_code = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_code  <= START_CODE_RST;
            cfg_reg.end_code    <= END_CODE_RST;
            cfg_reg.escape_code <= ESCAPE_CODE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ src/efd_crc8_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "escaped_frame_deframer_crc8_core_defines.svh"

module efd_crc8_step (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  efd_crc8_pkg::cfg_t cfg,
    efd_crc8_rx_if.sink        rx,
    efd_crc8_res_if.source     res
);
    import efd_crc8_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PAYLOAD_SIZE - 2);

    mode_t            mode_reg, mode_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       held_reg, held_next;
    logic [7:0]       crc_reg, crc_next;

    logic             res_valid_reg, res_valid_next;
    kind_t            res_kind_reg, res_kind_next;
    logic [7:0]       res_data_reg, res_data_next;
    logic [5:0]       res_len_reg, res_len_next;

    logic             in_ready;
    logic             acc;
    logic [7:0]       c;
    logic [7:0]       pay_byte;
    logic             in_frame;
    logic             is_open, is_esc, is_restart, is_end, is_cmd, is_take;
    logic             ovf, first;
    logic             emit;
    kind_t            emit_kind;
    logic [7:0]       emit_data;
    logic [5:0]       emit_len;

    assign in_ready = !res_valid_reg || res.ready;
    assign acc      = rx.valid && in_ready;
    assign c        = rx.rx_byte;
    assign pay_byte = (mode_reg == MODE_ESC) ? (c ^ ESC_XOR) : c;

    // byte decode, escape before start before end
    assign in_frame   = (mode_reg == MODE_CMD) || (mode_reg == MODE_PAYLOAD);
    assign is_open    = (mode_reg == MODE_IDLE) && (c == cfg.start_code);
    assign is_esc     = in_frame && (c == cfg.escape_code);
    assign is_restart = in_frame && !is_esc && (c == cfg.start_code);
    assign is_end     = in_frame && !is_esc && !is_restart && (c == cfg.end_code);
    assign is_cmd     = (mode_reg == MODE_CMD) && !is_esc && !is_restart && !is_end;
    assign is_take    = (mode_reg == MODE_ESC)
                      || ((mode_reg == MODE_PAYLOAD) && !is_esc && !is_restart && !is_end);
    assign ovf        = cnt_reg >= CNT_MAX;
    assign first      = cnt_reg == '0;

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        cmd_next  = cmd_reg;
        held_next = held_reg;
        crc_next  = crc_reg;
        if (acc)
        begin
            if (is_open || is_restart)
            begin
                mode_next = MODE_CMD;
                cnt_next  = '0;
                cmd_next  = 8'd0;
                held_next = 8'd0;
                crc_next  = 8'd0;
            end
            else if (is_esc)
            begin
                mode_next = MODE_ESC;
            end
            else if (is_end)
            begin
                mode_next = MODE_IDLE;
            end
            else if (is_cmd)
            begin
                mode_next = MODE_PAYLOAD;
                cmd_next  = c;
            end
            else if (is_take)
            begin
                if (ovf)
                begin
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    mode_next = MODE_PAYLOAD;
                    held_next = pay_byte;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    if (!first)
                    begin
                        crc_next = crc_step(crc_reg, held_reg);
                    end
                end
            end
        end
    end

    // result
    always_comb
    begin
        emit      = 1'b0;
        emit_kind = KIND_CMD;
        emit_data = 8'd0;
        emit_len  = 6'd0;
        if (is_restart)
        begin
            emit      = 1'b1;
            emit_kind = KIND_ABANDON;
            emit_data = cmd_reg;
            emit_len  = delivered_len(cnt_reg);
        end
        else if (is_end)
        begin
            emit      = 1'b1;
            emit_kind = (!first && (crc_reg == held_reg)) ? KIND_GOOD : KIND_BAD;
            emit_data = cmd_reg;
            emit_len  = delivered_len(cnt_reg);
        end
        else if (is_cmd)
        begin
            emit      = 1'b1;
            emit_kind = KIND_CMD;
            emit_data = c;
        end
        else if (is_take)
        begin
            if (ovf)
            begin
                emit      = 1'b1;
                emit_kind = KIND_ABANDON;
                emit_data = cmd_reg;
                emit_len  = delivered_len(cnt_reg);
            end
            else if (!first)
            begin
                emit      = 1'b1;
                emit_kind = KIND_PAYLOAD;
                emit_data = held_reg;
            end
        end
    end

    assign res_valid_next = in_ready ? (acc && emit) : res_valid_reg;
    assign res_kind_next  = emit_kind;
    assign res_data_next  = emit_data;
    assign res_len_next   = emit_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            cnt_reg       <= '0;
            cmd_reg       <= 8'd0;
            held_reg      <= 8'd0;
            crc_reg       <= 8'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            cnt_reg       <= cnt_next;
            cmd_reg       <= cmd_next;
            held_reg      <= held_next;
            crc_reg       <= crc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && emit)
        begin
            res_kind_reg <= res_kind_next;
            res_data_reg <= res_data_next;
            res_len_reg  <= res_len_next;
        end
    end

    assign rx.ready         = in_ready;
    assign res.valid        = res_valid_reg;
    assign res.kind         = res_kind_reg;
    assign res.data         = res_data_reg;
    assign res.frame_length = res_len_reg;

    `EFD_ASSERT_IMPL(a_stall_blocks_rx, res_valid_reg && !res.ready, !rx.ready)
    `EFD_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_reg <= CNT_MAX)
    `EFD_ASSERT_IMPL(a_byte_len_zero, res_valid_reg && (res_kind_reg == KIND_CMD || res_kind_reg == KIND_PAYLOAD), res_len_reg == 6'd0)
    `EFD_ASSERT_NEXT(a_esc_leaves, acc && (mode_reg == MODE_ESC), mode_reg == MODE_PAYLOAD || mode_reg == MODE_IDLE)

endmodule

`default_nettype wire

@@ src/escaped_frame_deframer_crc8_core.sv @@
// A result is registered and valid in the cycle after the byte that causes it is transferred.
// Accepts one received byte per cycle; a stalled result holds off rx only while it waits.
// The per-byte decode and CRC-8 update are combinational between rx and the state and result registers.
// Reset (rst_n, async, active low): codes return to 192/193/219, deframer to idle, no result.
`timescale 1ns / 1ps
`default_nettype none

module escaped_frame_deframer_crc8_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    efd_crc8_rx_if.sink                             rx,
    efd_crc8_res_if.source                          res,
    input  wire logic                               cfg_we,
    input  wire logic [efd_crc8_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                         cfg_data
);
    import efd_crc8_pkg::*;

    cfg_t cfg;

    efd_crc8_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    efd_crc8_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .rx    (rx),
        .res   (res)
    );

endmodule

`default_nettype wire
